// ===== sv/tld_pkg.sv =====
package tld_pkg;

    // Operation codes carried on the action field.
    localparam logic [1:0] ACT_RX    = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_DRAIN = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    // Character codes used by the echo and output translation.
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_OFFSET = 8'd64;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_QMARK  = 8'h3f;

endpackage

// ===== sv/tld_ram.sv =====
module tld_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Single port: a write or a read each cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tty_line_discipline.sv =====
// Channel | Direction | Handshake                  | Word
// --------+-----------+----------------------------+------------------------------------
// in      | input     | i_in_valid / o_in_ready    | i_action, i_data_byte
// out     | output    | o_out_valid / i_out_ready  | o_out_byte, o_status, o_line_end
//
// One word at a time: a refused or empty operation or a single-byte push goes
// from the execute state to the done state; a two-byte push (one ring port, a
// write per byte) passes the second-byte state between them, a pop (registered
// memory read) the read-data state. Input is ready in the idle state. Reset is
// synchronous, active low, and clears state, output valid, pointers and counts.
// The input also waits while a result cannot enter the occupied output register.
module tty_line_discipline #(
    parameter int BUF_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_line_end
);

    import tld_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam logic [CW-1:0] FULL      = CW'(BUF_DEPTH);
    localparam logic [CW-1:0] ROOM_TWO  = CW'(BUF_DEPTH - 2);
    localparam logic [AW-1:0] LAST_POS  = AW'(BUF_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SECOND,
        S_RDATA,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [1:0]    r_action;
    logic [7:0]    r_byte;
    logic [7:0]    r_second;
    logic          r_from_line;
    logic [7:0]    r_res_byte;
    logic [1:0]    r_res_status;
    logic          r_res_end;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [1:0]    r_out_status;
    logic          r_out_end;

    logic [AW-1:0] r_line_head;
    logic [AW-1:0] r_line_tail;
    logic [CW-1:0] r_line_count;
    logic [CW-1:0] r_release_count;
    logic [AW-1:0] r_ring_wpos;
    logic [AW-1:0] r_ring_rpos;
    logic [CW-1:0] r_ring_count;

    logic          is_rx;
    logic          is_write;
    logic          len_two;
    logic          room_one;
    logic          room_two;
    logic          rx_ok;
    logic          write_ok;
    logic          push_two;
    logic [7:0]    first_byte;
    logic [7:0]    second_byte;
    logic [CW-1:0] n_line_count;

    logic          ring_we;
    logic [AW-1:0] ring_addr;
    logic [7:0]    ring_wdata;
    logic [7:0]    ring_rdata;
    logic          line_we;
    logic [AW-1:0] line_addr;
    logic [7:0]    line_wdata;
    logic [7:0]    line_rdata;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] pos);
        next_pos = (pos == LAST_POS) ? '0 : pos + AW'(1);
    endfunction

    // Decode of the held word: room checks and the bytes to be pushed.
    always_comb begin
        is_rx    = (r_action == ACT_RX);
        is_write = (r_action == ACT_WRITE);
        len_two  = (r_byte < CH_SPACE) || (r_byte == CH_DEL);
        room_one = (r_ring_count != FULL);
        room_two = (r_ring_count <= ROOM_TWO);
        rx_ok    = (r_line_count != FULL) && (len_two ? room_two : room_one);
        write_ok = (r_byte == CH_LF) ? room_two : room_one;
        push_two = is_rx ? len_two : (r_byte == CH_LF);
        n_line_count = r_line_count + CW'(1);

        if (is_rx) begin
            if (r_byte == CH_CR) begin
                first_byte  = CH_CR;
                second_byte = CH_LF;
            end else if (len_two) begin
                first_byte  = CH_CARET;
                second_byte = (r_byte == CH_DEL) ? CH_QMARK : r_byte + CH_OFFSET;
            end else begin
                first_byte  = r_byte;
                second_byte = r_byte;
            end
        end else begin
            first_byte  = (r_byte == CH_LF) ? CH_CR : r_byte;
            second_byte = CH_LF;
        end
    end

    // Memory port control: the ring writes in the execute and second-byte cycles,
    // the line store in execute only; otherwise each port reads at its pop position.
    always_comb begin
        ring_we    = ((r_state == S_EXEC) && ((is_rx && rx_ok) || (is_write && write_ok)))
                     || (r_state == S_SECOND);
        ring_addr  = ring_we ? r_ring_wpos : r_ring_rpos;
        ring_wdata = (r_state == S_SECOND) ? r_second : first_byte;
        line_we    = (r_state == S_EXEC) && is_rx && rx_ok;
        line_addr  = line_we ? r_line_tail : r_line_head;
        line_wdata = (r_byte == CH_CR) ? CH_LF : r_byte;
    end

    tld_ram #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_echo_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_addr  (ring_addr),
        .i_wdata (ring_wdata),
        .o_rdata (ring_rdata)
    );

    tld_ram #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_addr  (line_addr),
        .i_wdata (line_wdata),
        .o_rdata (line_rdata)
    );

    // Sequencer, queue pointers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_line_head     <= '0;
            r_line_tail     <= '0;
            r_line_count    <= '0;
            r_release_count <= '0;
            r_ring_wpos     <= '0;
            r_ring_rpos     <= '0;
            r_ring_count    <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_action <= i_action;
                        r_byte   <= i_data_byte;
                        r_state  <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    r_res_byte   <= '0;
                    r_res_status <= ST_DONE;
                    r_res_end    <= 1'b0;
                    r_second     <= second_byte;
                    r_state      <= S_DONE;
                    case (r_action)
                        ACT_RX: begin
                            if (!rx_ok) begin
                                r_res_status <= ST_REFUSED;
                            end else begin
                                r_line_tail  <= next_pos(r_line_tail);
                                r_line_count <= n_line_count;
                                if ((r_byte == CH_CR) || (n_line_count == FULL)) begin
                                    r_release_count <= n_line_count;
                                end
                                r_ring_wpos  <= next_pos(r_ring_wpos);
                                r_ring_count <= r_ring_count + CW'(1);
                                if (push_two) begin
                                    r_state <= S_SECOND;
                                end
                            end
                        end
                        ACT_WRITE: begin
                            if (!write_ok) begin
                                r_res_status <= ST_REFUSED;
                            end else begin
                                r_ring_wpos  <= next_pos(r_ring_wpos);
                                r_ring_count <= r_ring_count + CW'(1);
                                if (push_two) begin
                                    r_state <= S_SECOND;
                                end
                            end
                        end
                        ACT_DRAIN: begin
                            if (r_ring_count == '0) begin
                                r_res_status <= ST_EMPTY;
                            end else begin
                                r_ring_rpos  <= next_pos(r_ring_rpos);
                                r_ring_count <= r_ring_count - CW'(1);
                                r_from_line  <= 1'b0;
                                r_state      <= S_RDATA;
                            end
                        end
                        default: begin
                            if ((r_release_count == '0) || (r_line_count == '0)) begin
                                r_res_status <= ST_EMPTY;
                            end else begin
                                r_line_head     <= next_pos(r_line_head);
                                r_line_count    <= r_line_count - CW'(1);
                                r_release_count <= r_release_count - CW'(1);
                                r_res_end       <= (r_release_count == CW'(1));
                                r_from_line     <= 1'b1;
                                r_state         <= S_RDATA;
                            end
                        end
                    endcase
                end

                S_SECOND: begin
                    r_ring_wpos  <= next_pos(r_ring_wpos);
                    r_ring_count <= r_ring_count + CW'(1);
                    r_state      <= S_DONE;
                end

                S_RDATA: begin
                    r_res_byte <= r_from_line ? line_rdata : ring_rdata;
                    r_state    <= S_DONE;
                end

                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_byte   <= r_res_byte;
                        r_out_status <= r_res_status;
                        r_out_end    <= r_res_end;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_status    = r_out_status;
    assign o_line_end  = r_out_end;

endmodule
